>>> rtl/positional_list_store_unit_assert.svh
// Assertion macros for the positional list store unit.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH

// Check a condition that must hold in the same cycle as its trigger
`define PLSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition that must hold in the cycle after its trigger
`define PLSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/plsu_pkg.sv
// Shared types and codes for the positional list store unit.
// No dependencies; used by positional_list_store_unit and plsu_seq.
package plsu_pkg;

    // Command codes
    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [2:0] CMD_DEL_POS   = 3'd5;
    localparam logic [2:0] CMD_DUMP      = 3'd6;

    // Status codes
    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    // Largest number of elements a dump emits
    localparam int unsigned MaxDump = 16;

    localparam int unsigned ValueW = 32;

    typedef struct packed {
        logic [2:0]               command;
        logic signed [ValueW-1:0] value;
        logic [4:0]               position;
    } cmd_t;

    typedef struct packed {
        logic [4:0]               item_count;
        logic [1:0]               status;
        logic signed [ValueW-1:0] element;
        logic                     element_valid;
        logic                     last;
    } rsp_t;

endpackage

>>> rtl/positional_list_store_unit.sv
// Top level of the positional list store unit: sequencer plus slot RAM.
// Depends on plsu_pkg, plsu_seq, plsu_ram and positional_list_store_unit_assert.svh.

// Ordered store of up to DEPTH signed 32-bit values kept front to back in a
// single slot RAM. One command is taken at a time; cmd_ready is low until its
// last response has been loaded into the output register. Moving elements goes
// through the RAM's one read and one write port with one shared step unit: an
// insert checks the cursor, reads and writes back each element behind the
// target slot, then writes the new value and responds; a delete moves each
// element after the removed one the same way and then responds; a rejected or
// ignored command goes straight to its status response. A dump reads up to
// 16 elements, presenting each once the response side has room. The response
// register lets a new command enter while the previous response waits.
module positional_list_store_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_ready,
    input  plsu_pkg::cmd_t cmd,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output plsu_pkg::rsp_t rsp
);

`include "positional_list_store_unit_assert.svh"

    localparam int unsigned AW = $clog2(DEPTH);

    logic                          mem_we;
    logic [AW-1:0]                 mem_waddr;
    logic [plsu_pkg::ValueW-1:0]   mem_wdata;
    logic                          mem_re;
    logic [AW-1:0]                 mem_raddr;
    logic [plsu_pkg::ValueW-1:0]   mem_rdata;

    // Command sequencer
    plsu_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Slot storage
    plsu_ram #(
        .WIDTH (plsu_pkg::ValueW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer leaves idle on every accepted request
    `PLSU_ASSERT_NEXT(a_busy_after_accept, cmd_valid && cmd_ready, !cmd_ready, "ready after accept")
    // Status responses carry no element
    `PLSU_ASSERT_NOW(a_no_elem_zero, rsp_valid && !rsp.element_valid, rsp.element == '0, "stray elem")
    // Only dump elements may be followed by further responses
    `PLSU_ASSERT_NOW(a_nonlast_is_elem, rsp_valid && !rsp.last, rsp.element_valid, "bad non-last")
    // Shift loop never reads and writes the RAM in one cycle
    `PLSU_ASSERT_NOW(a_ram_one_op, mem_we, !mem_re, "RAM read and write overlap")

endmodule

>>> rtl/plsu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plsu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; hold data while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/plsu_seq.sv
// Sequencer for the positional list store: command decode, shift loop over
// the slot RAM with one shared step unit, and the response register.
// Depends on plsu_pkg.
module plsu_seq #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cmd_valid,
    output logic                                  cmd_ready,
    input  plsu_pkg::cmd_t                        cmd,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output plsu_pkg::rsp_t                        rsp,
    output logic                                  mem_we,
    output logic [$clog2(DEPTH)-1:0]              mem_waddr,
    output logic [plsu_pkg::ValueW-1:0]           mem_wdata,
    output logic                                  mem_re,
    output logic [$clog2(DEPTH)-1:0]              mem_raddr,
    input  logic [plsu_pkg::ValueW-1:0]           mem_rdata
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = ((CW > 5) ? CW : 5) + 1;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_INS_CHK  = 9'b000000010,
        S_DEL_CHK  = 9'b000000100,
        S_SH_RD    = 9'b000001000,
        S_SH_WR    = 9'b000010000,
        S_PUT      = 9'b000100000,
        S_RESP     = 9'b001000000,
        S_DUMP_RD  = 9'b010000000,
        S_DUMP_CAP = 9'b100000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CW-1:0]              fill_reg, fill_next;
    logic [CW-1:0]              cur_reg, cur_next;
    logic [CW-1:0]              tgt_reg, tgt_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       up_reg, up_next;
    logic [1:0]                 status_reg, status_next;
    logic [plsu_pkg::ValueW-1:0] val_reg, val_next;
    logic                       out_valid_reg, out_valid_next;
    plsu_pkg::rsp_t             out_reg, out_next;

    logic [CW-1:0] step;
    logic          out_free;
    logic          accept;
    logic [PW-1:0] pos_w;
    logic [PW-1:0] fill_w;
    logic          full;
    logic          empty;

    // Shared step unit: advance the cursor by one in the active direction
    assign step = up_reg ? (cur_reg + CW'(1)) : (cur_reg - CW'(1));

    assign out_free = !out_valid_reg || rsp_ready;
    assign accept   = cmd_valid && cmd_ready;
    assign pos_w    = PW'(cmd.position);
    assign fill_w   = PW'(fill_reg);
    assign full     = (fill_reg == CW'(DEPTH));
    assign empty    = (fill_reg == '0);

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // Next-state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cur_next       = cur_reg;
        tgt_next       = tgt_reg;
        cnt_next       = cnt_reg;
        up_next        = up_reg;
        status_next    = status_reg;
        val_next       = val_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg[AW-1:0];
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = step[AW-1:0];

        // Drop the held response once taken
        if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    val_next    = cmd.value;
                    status_next = plsu_pkg::STAT_DONE;
                    state_next  = S_RESP;
                    unique case (cmd.command)
                        plsu_pkg::CMD_INS_FRONT, plsu_pkg::CMD_INS_BACK:
                        begin
                            if (full)
                            begin
                                status_next = plsu_pkg::STAT_FULL;
                            end
                            else
                            begin
                                up_next    = 1'b0;
                                cur_next   = fill_reg;
                                tgt_next   = (cmd.command == plsu_pkg::CMD_INS_FRONT)
                                             ? '0 : fill_reg;
                                state_next = S_INS_CHK;
                            end
                        end
                        plsu_pkg::CMD_INS_POS:
                        begin
                            if (pos_w == '0 || pos_w > fill_w + PW'(1))
                            begin
                                status_next = plsu_pkg::STAT_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = plsu_pkg::STAT_FULL;
                            end
                            else
                            begin
                                up_next    = 1'b0;
                                cur_next   = fill_reg;
                                tgt_next   = CW'(pos_w - PW'(1));
                                state_next = S_INS_CHK;
                            end
                        end
                        plsu_pkg::CMD_DEL_FRONT, plsu_pkg::CMD_DEL_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = plsu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                up_next    = 1'b1;
                                cur_next   = (cmd.command == plsu_pkg::CMD_DEL_FRONT)
                                             ? '0 : (fill_reg - CW'(1));
                                state_next = S_DEL_CHK;
                            end
                        end
                        plsu_pkg::CMD_DEL_POS:
                        begin
                            if (empty)
                            begin
                                status_next = plsu_pkg::STAT_EMPTY;
                            end
                            else if (pos_w == '0 || pos_w > fill_w)
                            begin
                                status_next = plsu_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                up_next    = 1'b1;
                                cur_next   = CW'(pos_w - PW'(1));
                                state_next = S_DEL_CHK;
                            end
                        end
                        plsu_pkg::CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                status_next = plsu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                up_next    = 1'b1;
                                cur_next   = '0;
                                cnt_next   = (fill_w > PW'(plsu_pkg::MaxDump))
                                             ? CW'(plsu_pkg::MaxDump) : fill_reg;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            status_next = plsu_pkg::STAT_DONE;
                        end
                    endcase
                end
            end

            // Shift toward the back until the gap reaches the target
            S_INS_CHK:
            begin
                state_next = (cur_reg > tgt_reg) ? S_SH_RD : S_PUT;
            end

            // Shift toward the front while a successor remains
            S_DEL_CHK:
            begin
                if (step < fill_reg)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_RESP;
                end
            end

            S_SH_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                mem_we     = 1'b1;
                cur_next   = step;
                state_next = up_reg ? S_DEL_CHK : S_INS_CHK;
            end

            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = tgt_reg[AW-1:0];
                mem_wdata  = val_reg;
                fill_next  = fill_reg + CW'(1);
                state_next = S_RESP;
            end

            // Emit the single status response
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.item_count    = 5'(fill_reg);
                    out_next.status        = status_reg;
                    out_next.element       = '0;
                    out_next.element_valid = 1'b0;
                    out_next.last          = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            S_DUMP_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = cur_reg[AW-1:0];
                state_next = S_DUMP_CAP;
            end

            // Present one element; read data holds until the next read
            S_DUMP_CAP:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.item_count    = 5'(fill_reg);
                    out_next.status        = plsu_pkg::STAT_DONE;
                    out_next.element       = $signed(mem_rdata);
                    out_next.element_valid = 1'b1;
                    out_next.last          = (step == cnt_reg);
                    cur_next               = step;
                    state_next             = (step == cnt_reg) ? S_IDLE : S_DUMP_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and loop registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        tgt_reg    <= tgt_next;
        cnt_reg    <= cnt_next;
        up_reg     <= up_next;
        status_reg <= status_next;
        val_reg    <= val_next;
        out_reg    <= out_next;
    end

endmodule
